[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hw/rtl/sbe_pkg.sv]
package sbe_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_BITS   = 16;
    localparam int ACT_BITS   = 3;
    // Numerator magnitude bits (products of two coordinates plus margin).
    localparam int NUM_BITS   = 2 * COORD_BITS + 3;
    // Divisor magnitude bits.
    localparam int DEN_BITS   = COORD_BITS;
    // Quotient magnitude bits kept before saturation.
    localparam int Q_BITS     = NUM_BITS;
    // Divider bits resolved per stage.
    localparam int BITS_PER_STAGE = 3;
    localparam int DIV_STAGES = (Q_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int Q_PAD      = DIV_STAGES * BITS_PER_STAGE;

    localparam logic [ACT_BITS-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_LEFT   = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_RIGHT  = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_BOTTOM = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_ZDIV   = 3'd4;

    localparam logic [1:0] REG_NEAR   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [OUT_BITS-1:0] t_out;

    // Side information that follows the quotient through the divider.
    typedef struct packed {
        t_coord                x1;
        t_coord                y1;
        t_coord                x2;
        t_coord                y2;
        logic [ACT_BITS-1:0]   action;
        logic                  move_start;
        t_coord                border;
        logic                  neg;
    } t_side;

    // Saturate a signed value to the 16-bit output range.
    function automatic t_out sat16(input logic signed [Q_BITS:0] v);
        logic signed [Q_BITS:0] hi;
        logic signed [Q_BITS:0] lo;
        begin
            hi = (Q_BITS+1)'(32767);
            lo = -(Q_BITS+1)'(32768);
            if (v > hi) begin
                sat16 = 16'sh7fff;
            end else if (v < lo) begin
                sat16 = 16'sh8000;
            end else begin
                sat16 = v[OUT_BITS-1:0];
            end
        end
    endfunction

endpackage

[hw/rtl/sbe_front.sv]
// Decide the case, build numerator and divisor over three register stages.
module sbe_front import sbe_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_coord                  i_x1,
    input  t_coord                  i_y1,
    input  t_coord                  i_x2,
    input  t_coord                  i_y2,
    input  t_coord                  i_near,
    input  t_coord                  i_width,
    input  t_coord                  i_height,
    output logic                    o_valid,
    output logic [NUM_BITS-1:0]     o_num,
    output logic [DEN_BITS-1:0]     o_den,
    output t_side                   o_side
);
    localparam int SW = COORD_BITS + 2;
    localparam int PW = 2 * COORD_BITS + 4;

    // Stage 1: threshold tests and differences.
    logic                  r_v1;
    t_coord                r_x1, r_y1, r_x2, r_y2, r_w, r_h;
    logic [ACT_BITS-1:0]   r_act1;
    logic                  r_ms1;
    logic signed [SW-1:0]  r_dx1, r_dy1;
    logic signed [SW-1:0]  n_dx1, n_dy1, thr_x, thr_y;
    logic [ACT_BITS-1:0]   n_act1;
    logic                  n_ms1;

    always_comb begin
        n_dx1 = SW'(signed'({1'b0, i_x2})) - SW'(signed'({1'b0, i_x1}));
        n_dy1 = SW'(signed'({1'b0, i_y2})) - SW'(signed'({1'b0, i_y1}));
        thr_x = SW'(signed'({1'b0, i_width})) - SW'(signed'({1'b0, i_near}));
        thr_y = SW'(signed'({1'b0, i_height})) - SW'(signed'({1'b0, i_near}));
        n_ms1 = i_y1 > i_y2;
        if (i_x1 < i_near) begin
            n_act1 = (n_dx1 == '0) ? ACT_ZDIV : ACT_LEFT;
        end else if (SW'(signed'({1'b0, i_x2})) > thr_x) begin
            n_act1 = (n_dx1 == '0) ? ACT_ZDIV : ACT_RIGHT;
        end else if (SW'(signed'({1'b0, i_y1})) > thr_y ||
                     SW'(signed'({1'b0, i_y2})) > thr_y) begin
            n_act1 = (n_dy1 == '0) ? ACT_ZDIV : ACT_BOTTOM;
        end else begin
            n_act1 = ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_x1 <= i_x1; r_y1 <= i_y1; r_x2 <= i_x2; r_y2 <= i_y2;
            r_w <= i_width; r_h <= i_height;
            r_act1 <= n_act1; r_ms1 <= n_ms1;
            r_dx1 <= n_dx1; r_dy1 <= n_dy1;
        end
    end

    // Stage 2: the two products of each formula.
    logic                  r_v2;
    t_side                 r_s2;
    logic signed [PW-1:0]  r_pa, r_pb;
    logic signed [SW-1:0]  r_den2;
    logic signed [PW-1:0]  n_pa, n_pb;
    logic signed [SW-1:0]  n_den2;
    logic signed [SW-1:0]  sx1, sy1, sx2, sy2, sw, sh;

    always_comb begin
        sx1 = SW'(signed'({1'b0, r_x1}));
        sy1 = SW'(signed'({1'b0, r_y1}));
        sx2 = SW'(signed'({1'b0, r_x2}));
        sy2 = SW'(signed'({1'b0, r_y2}));
        sw  = SW'(signed'({1'b0, r_w}));
        sh  = SW'(signed'({1'b0, r_h}));
        n_den2 = r_dx1;
        case (r_act1)
            ACT_RIGHT: begin
                n_pa = PW'(r_dy1 * (sw - sx2));
                n_pb = PW'(sy2 * r_dx1);
            end
            ACT_BOTTOM: begin
                n_pa = PW'(sh * r_dx1);
                n_pb = PW'(sy2 * sx1) - PW'(sy1 * sx2);
                n_den2 = r_dy1;
            end
            default: begin
                n_pa = PW'(sy1 * sx2);
                n_pb = -PW'(sy2 * sx1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_s2.x1 <= r_x1; r_s2.y1 <= r_y1; r_s2.x2 <= r_x2; r_s2.y2 <= r_y2;
            r_s2.action <= r_act1;
            r_s2.move_start <= r_ms1;
            r_s2.border <= (r_act1 == ACT_RIGHT) ? r_w : r_h;
            r_s2.neg <= 1'b0;
            r_pa <= n_pa; r_pb <= n_pb; r_den2 <= n_den2;
        end
    end

    // Stage 3: sum, then signs and magnitudes for the divider.
    logic signed [PW-1:0]  num_s;
    logic                  num_neg, den_neg;
    logic [PW-1:0]         num_mag;
    logic [SW-1:0]         den_mag;
    t_side                 n_side;

    always_comb begin
        num_s   = r_pa + r_pb;
        num_neg = num_s[PW-1];
        den_neg = r_den2[SW-1];
        num_mag = num_neg ? PW'(-num_s) : PW'(num_s);
        den_mag = den_neg ? SW'(-r_den2) : SW'(r_den2);
        n_side     = r_s2;
        n_side.neg = num_neg ^ den_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
        if (i_en) begin
            o_side     <= n_side;
            o_num      <= num_mag[NUM_BITS-1:0];
            o_den      <= den_mag[DEN_BITS-1:0];
        end
    end
endmodule

[hw/rtl/sbe_div.sv]
// Pipelined restoring divider, a few quotient bits per stage.
module sbe_div import sbe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [Q_PAD-1:0]    o_quo,
    output t_side               o_side
);
    localparam int RW = DEN_BITS + 1;

    logic                   r_v   [DIV_STAGES+1];
    logic [Q_PAD-1:0]       r_n   [DIV_STAGES+1];
    logic [RW-1:0]          r_rem [DIV_STAGES+1];
    logic [DEN_BITS-1:0]    r_d   [DIV_STAGES+1];
    t_side                  r_s   [DIV_STAGES+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_n[0]   = Q_PAD'(i_num);
        r_rem[0] = '0;
        r_d[0]   = i_den;
        r_s[0]   = i_side;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [Q_PAD-1:0] n_n;
        logic [RW-1:0]    n_rem;
        logic [RW:0]      trial;

        // For each bit of the stage, shift in one numerator bit, subtract the divisor where it fits.
        always_comb begin
            n_n   = r_n[g];
            n_rem = r_rem[g];
            trial = '0;
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                trial = {n_rem, n_n[Q_PAD-1]};
                n_n   = {n_n[Q_PAD-2:0], 1'b0};
                if (trial >= (RW+1)'(r_d[g])) begin
                    trial = trial - (RW+1)'(r_d[g]);
                    n_n[0] = 1'b1;
                end
                n_rem = trial[RW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_n[g+1]   <= n_n;
                r_rem[g+1] <= n_rem;
                r_d[g+1]   <= r_d[g];
                r_s[g+1]   <= r_s[g];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_quo   = r_n[DIV_STAGES];
    assign o_side  = r_s[DIV_STAGES];
endmodule

[hw/rtl/sbe_back.sv]
// Sign, saturate and place the quotient into the result item.
module sbe_back import sbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [Q_PAD-1:0]   i_quo,
    input  t_side              i_side,
    output logic               o_valid,
    output t_out               o_sx,
    output t_out               o_sy,
    output t_out               o_ex,
    output t_out               o_ey,
    output logic [ACT_BITS-1:0] o_action
);
    logic signed [Q_BITS:0] q_s;
    t_out  q_sat, px1, py1, px2, py2, pb;
    t_out  n_sx, n_sy, n_ex, n_ey;

    always_comb begin
        q_s   = i_side.neg ? -signed'({1'b0, i_quo[Q_BITS-1:0]})
                           : signed'({1'b0, i_quo[Q_BITS-1:0]});
        q_sat = sat16(q_s);
        px1 = t_out'({1'b0, i_side.x1});
        py1 = t_out'({1'b0, i_side.y1});
        px2 = t_out'({1'b0, i_side.x2});
        py2 = t_out'({1'b0, i_side.y2});
        pb  = t_out'({1'b0, i_side.border});
        n_sx = px1; n_sy = py1; n_ex = px2; n_ey = py2;
        case (i_side.action)
            ACT_LEFT: begin
                n_sx = '0;
                n_sy = q_sat;
            end
            ACT_RIGHT: begin
                n_ex = pb;
                n_ey = q_sat;
            end
            ACT_BOTTOM: begin
                if (i_side.move_start) begin
                    n_sx = q_sat; n_sy = pb;
                end else begin
                    n_ex = q_sat; n_ey = pb;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_sx <= n_sx; o_sy <= n_sy; o_ex <= n_ex; o_ey <= n_ey;
            o_action <= i_side.action;
        end
    end
endmodule

[hw/rtl/segment_border_extend.sv]
// Channel | Direction | Handshake                  | Payload
// input   | in        | i_valid / o_ready          | i_start_x, i_start_y, i_end_x, i_end_y
// output  | out       | o_valid / i_ready          | o_new_start_x .. o_new_end_y, o_action
// config  | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
// One item enters per cycle while o_ready is high; each result passes through the three
// front stages, the DIV_STAGES divider stages and the back stage; the divider resolves
// three quotient bits per stage.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults (near 150, width 640, height 480).
// The whole pipeline advances together while the output stage is empty or taken.
`include "assert_macros.svh"
module segment_border_extend import sbe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_coord              i_start_x,
    input  t_coord              i_start_y,
    input  t_coord              i_end_x,
    input  t_coord              i_end_y,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out                o_new_start_x,
    output t_out                o_new_start_y,
    output t_out                o_new_end_x,
    output t_out                o_new_end_y,
    output logic [ACT_BITS-1:0] o_action,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  t_coord              i_cfg_data
);
    t_coord r_near, r_width, r_height;
    logic   en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= COORD_BITS'(150);
            r_width  <= COORD_BITS'(640);
            r_height <= COORD_BITS'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NEAR:   r_near   <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves when the last stage is free or being drained.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic                f_valid;
    logic [NUM_BITS-1:0] f_num;
    logic [DEN_BITS-1:0] f_den;
    t_side               f_side;
    logic                d_valid;
    logic [Q_PAD-1:0]    d_quo;
    t_side               d_side;

    sbe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_x1(i_start_x), .i_y1(i_start_y), .i_x2(i_end_x), .i_y2(i_end_y),
        .i_near(r_near), .i_width(r_width), .i_height(r_height),
        .o_valid(f_valid), .o_num(f_num), .o_den(f_den), .o_side(f_side)
    );

    sbe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_valid),
        .i_num(f_num), .i_den(f_den), .i_side(f_side),
        .o_valid(d_valid), .o_quo(d_quo), .o_side(d_side)
    );

    sbe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_valid),
        .i_quo(d_quo), .i_side(d_side),
        .o_valid(o_valid), .o_sx(o_new_start_x), .o_sy(o_new_start_y),
        .o_ex(o_new_end_x), .o_ey(o_new_end_y), .o_action(o_action)
    );

    // A stalled result keeps its action.
    `ASSERT_NEXT(a_hold_action, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_action), "action changed under stall")
    // Action codes above the zero-divisor code never appear.
    `ASSERT_IMPL(a_action_range, i_clk, i_rst_n, o_valid, o_action <= ACT_ZDIV, "bad action code")
    // Ready follows the output stage exactly.
    `ASSERT_IMPL(a_ready, i_clk, i_rst_n, 1'b1, o_ready == (!o_valid || i_ready), "ready mismatch")
endmodule

[tb/tb_segment_border_extend.sv]
module tb_segment_border_extend;
    import sbe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 3 + DIV_STAGES + 1 + 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 230;

    // One expected result of the extender.
    typedef struct {
        t_out                sx;
        t_out                sy;
        t_out                ex;
        t_out                ey;
        logic [ACT_BITS-1:0] act;
    } t_extended;

    // One row of the directed table; has_exp marks a result typed in by hand.
    typedef struct {
        int unsigned x1, y1, x2, y2;
        bit          has_exp;
        t_extended   exp;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_coord              i_start_x = '0;
    t_coord              i_start_y = '0;
    t_coord              i_end_x = '0;
    t_coord              i_end_y = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_out                o_new_start_x;
    t_out                o_new_start_y;
    t_out                o_new_end_x;
    t_out                o_new_end_y;
    logic [ACT_BITS-1:0] o_action;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = REG_NEAR;
    t_coord              i_cfg_data = '0;

    // Predictor copy of the border registers.
    longint near_px = 150;
    longint width_px = 640;
    longint height_px = 480;

    t_extended pending_segments[$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        item_taken = 1'b0;
    bit        result_taken = 1'b0;
    t_extended seen;
    int        quiet_cycles = 0;

    segment_border_extend i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic t_out clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_out'(v);
    endfunction

    // Extend one segment to the border that its endpoints are near.
    function automatic t_extended extend_segment(input longint x1, input longint y1,
                                                 input longint x2, input longint y2);
        longint dx, dy, nx1, ny1, nx2, ny2, ythr, xb;
        t_extended r;
        dx = x2 - x1;
        dy = y2 - y1;
        nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2;
        ythr = height_px - near_px;
        r.act = ACT_NONE;
        if (x1 < near_px) begin
            if (dx == 0) begin
                r.act = ACT_ZDIV;
            end else begin
                nx1 = 0;
                ny1 = (y1 * x2 - y2 * x1) / dx;
                r.act = ACT_LEFT;
            end
        end else if (x2 > width_px - near_px) begin
            if (dx == 0) begin
                r.act = ACT_ZDIV;
            end else begin
                nx2 = width_px;
                ny2 = (dy * (width_px - x2) + y2 * dx) / dx;
                r.act = ACT_RIGHT;
            end
        end else if (y1 > ythr || y2 > ythr) begin
            if (dy == 0) begin
                r.act = ACT_ZDIV;
            end else begin
                xb = (height_px * dx - y1 * x2 + y2 * x1) / dy;
                // On a tie the end point is the one that moves.
                if (y1 > y2) begin
                    nx1 = xb;
                    ny1 = height_px;
                end else begin
                    nx2 = xb;
                    ny2 = height_px;
                end
                r.act = ACT_BOTTOM;
            end
        end
        r.sx = clamp16(nx1);
        r.sy = clamp16(ny1);
        r.ex = clamp16(nx2);
        r.ey = clamp16(ny2);
        return r;
    endfunction

    // Offer one segment and hold it until the block takes it.
    task automatic send_segment(input int unsigned x1, input int unsigned y1,
                                input int unsigned x2, input int unsigned y2,
                                input bit has_exp, input t_extended exp);
        t_extended want;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_start_x <= t_coord'(x1);
        i_start_y <= t_coord'(y1);
        i_end_x   <= t_coord'(x2);
        i_end_y   <= t_coord'(y2);
        forever begin
            @(negedge i_clk);
            if (o_ready) begin
                if (has_exp) begin
                    want = exp;
                end else begin
                    want = extend_segment(x1 & 12'hfff, y1 & 12'hfff,
                                          x2 & 12'hfff, y2 & 12'hfff);
                end
                pending_segments.insert(pending_segments.size(), want);
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    // Registers change only once the pipeline has emptied.
    task automatic set_borders(input int unsigned near_v, input int unsigned width_v,
                               input int unsigned height_v);
        i_valid <= 1'b0;
        wait (pending_segments.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_NEAR;
        i_cfg_data <= t_coord'(near_v);
        @(posedge i_clk);
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= t_coord'(width_v);
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data <= t_coord'(height_v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        near_px = near_v;
        width_px = width_v;
        height_px = height_v;
    endtask

    // A coordinate either fully random or close to one of the edge thresholds.
    function automatic int unsigned pick_coord(input longint center);
        longint v;
        if ($urandom_range(3) == 0) return $urandom_range(4095);
        v = center + $signed($urandom_range(10)) - 5;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return int'(v);
    endfunction

    // Receiver side stalls at random.
    always @(posedge i_clk) begin
        i_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Handshakes are sampled mid-cycle so the edge itself is race free.
    always @(negedge i_clk) begin
        item_taken   <= i_valid && o_ready;
        result_taken <= o_valid && i_ready;
        seen.sx  <= o_new_start_x;
        seen.sy  <= o_new_start_y;
        seen.ex  <= o_new_end_x;
        seen.ey  <= o_new_end_y;
        seen.act <= o_action;
    end

    // Compare each result with the oldest expected segment.
    always @(posedge i_clk) begin
        t_extended want;
        if (result_taken) begin
            if (pending_segments.size() == 0) begin
                report_mismatch("result with no segment outstanding");
            end else begin
                want = pending_segments.pop_front();
                if (seen.sx !== want.sx)
                    report_mismatch($sformatf("new_start_x %0d want %0d", seen.sx, want.sx));
                if (seen.sy !== want.sy)
                    report_mismatch($sformatf("new_start_y %0d want %0d", seen.sy, want.sy));
                if (seen.ex !== want.ex)
                    report_mismatch($sformatf("new_end_x %0d want %0d", seen.ex, want.ex));
                if (seen.ey !== want.ey)
                    report_mismatch($sformatf("new_end_y %0d want %0d", seen.ey, want.ey));
                if (seen.act !== want.act)
                    report_mismatch($sformatf("action %0d want %0d", seen.act, want.act));
            end
        end
    end

    // Watchdog on cycles where neither channel moves.
    always @(posedge i_clk) begin
        if (item_taken || result_taken) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[segment_border_extend] ERROR");
            $finish;
        end
    end

    initial begin
        t_row directed[$];
        t_row row;
        t_extended none_exp;
        int unsigned cfgs[8][3];
        int unsigned x1, y1, x2, y2;
        none_exp = '{default: '0};

        // Hand-checked rows use the reset borders 150, 640, 480.
        directed.insert(directed.size(), '{0, 0, 0, 0, 1, '{0, 0, 0, 0, ACT_ZDIV}});
        directed.insert(directed.size(), '{4095, 4095, 4095, 4095, 1,
                        '{4095, 4095, 4095, 4095, ACT_ZDIV}});
        directed.insert(directed.size(),
                        '{100, 50, 100, 300, 1, '{100, 50, 100, 300, ACT_ZDIV}});
        directed.insert(directed.size(),
                        '{600, 20, 600, 90, 1, '{600, 20, 600, 90, ACT_ZDIV}});
        directed.insert(directed.size(),
                        '{200, 400, 450, 400, 1, '{200, 400, 450, 400, ACT_ZDIV}});
        directed.insert(directed.size(),
                        '{200, 100, 400, 200, 1, '{200, 100, 400, 200, ACT_NONE}});
        directed.insert(directed.size(),
                        '{300, 100, 300, 400, 1, '{300, 100, 300, 480, ACT_BOTTOM}});
        // Rows below are checked against the predictor.
        directed.insert(directed.size(), '{20, 100, 300, 250, 0, none_exp});
        directed.insert(directed.size(), '{149, 0, 150, 4095, 0, none_exp});
        directed.insert(directed.size(), '{149, 4095, 150, 0, 0, none_exp});
        directed.insert(directed.size(), '{200, 100, 550, 300, 0, none_exp});
        directed.insert(directed.size(), '{489, 0, 491, 4095, 0, none_exp});
        directed.insert(directed.size(), '{200, 400, 300, 200, 0, none_exp});
        directed.insert(directed.size(), '{200, 200, 300, 400, 0, none_exp});
        directed.insert(directed.size(), '{160, 350, 400, 350, 0, none_exp});
        directed.insert(directed.size(), '{450, 100, 200, 300, 0, none_exp});
        directed.insert(directed.size(), '{4095, 0, 0, 4095, 0, none_exp});
        directed.insert(directed.size(), '{2730, 1365, 1365, 2730, 0, none_exp});
        directed.insert(directed.size(), '{150, 331, 490, 330, 0, none_exp});

        cfgs = '{'{150, 640, 480}, '{0, 4095, 4095}, '{4095, 1, 1}, '{300, 100, 200},
                 '{1, 4095, 1}, '{4095, 4095, 4095}, '{64, 2048, 1024}, '{0, 1, 4095}};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            row = directed[i];
            send_segment(row.x1, row.y1, row.x2, row.y2, row.has_exp, row.exp);
        end

        for (int phase = 0; phase < 8; phase++) begin
            set_borders(cfgs[phase][0], cfgs[phase][1], cfgs[phase][2]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                x1 = pick_coord(near_px);
                x2 = pick_coord(width_px - near_px);
                y1 = pick_coord(height_px - near_px);
                y2 = pick_coord(height_px - near_px);
                // Degenerate vertical and horizontal segments, or fully random x coordinates.
                case ($urandom_range(9))
                    0: x2 = x1;
                    1: y2 = y1;
                    2: begin x1 = $urandom_range(4095); x2 = $urandom_range(4095); end
                    default: ;
                endcase
                send_segment(x1, y1, x2, y2, 1'b0, none_exp);
            end
        end

        i_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait (pending_segments.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[segment_border_extend] OK");
        end else begin
            $display("[segment_border_extend] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sbe_pkg.sv
hw/rtl/sbe_front.sv
hw/rtl/sbe_div.sv
hw/rtl/sbe_back.sv
hw/rtl/segment_border_extend.sv
tb/tb_segment_border_extend.sv
